// ===== src/uvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Unique value ring package
// Shared request, result and state types for the unique value ring.
// ----------------------------------------------------------------------------
package uvr_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_MOVE   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_SCAN,
    S_INS_DECIDE,
    S_INS_LINK1,
    S_INS_LINK2,
    S_REM_RD,
    S_REM_LINK,
    S_MV_DIV,
    S_MV_RD,
    S_MV_ADV,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  localparam int STEP_W = 16;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] item_value;
    logic signed [15:0] step_count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] current_value;
    logic               ring_empty;
    logic [4:0]         entry_count;
  } rsp_t;

endpackage

// ===== src/uvr_rem.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division that produces one dividend bit per cycle and returns
// only the remainder.
// ----------------------------------------------------------------------------
module uvr_rem #(
  parameter int DW = 16,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic            active, active_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [DW-1:0]   dvd, dvd_next;
  logic [VW-1:0]   rem, rem_next;
  logic            done_next;
  logic [VW:0]     trial;
  logic [VW:0]     diff;

  assign trial = {rem, dvd[DW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    active_next = active;
    cnt_next    = cnt;
    dvd_next    = dvd;
    rem_next    = rem;
    done_next   = 1'b0;
    if (start) begin
      active_next = 1'b1;
      cnt_next    = '0;
      dvd_next    = dividend;
      rem_next    = '0;
    end else if (active) begin
      dvd_next = {dvd[DW-2:0], 1'b0};
      rem_next = (trial >= {1'b0, divisor}) ? diff[VW-1:0] : trial[VW-1:0];
      cnt_next = cnt + 1'b1;
      if (cnt == CNTW'(DW - 1)) begin
        active_next = 1'b0;
        done_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      active <= active_next;
      done   <= done_next;
      cnt    <= cnt_next;
    end
    dvd <= dvd_next;
    rem <= rem_next;
  end

  assign remainder = rem;

endmodule

// ===== src/unique_value_ring_with_cursor_top.sv =====
// ----------------------------------------------------------------------------
// Unique value ring with cursor
// Bounded circular doubly linked ring of distinct signed values with a cursor.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and each item gives
// exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. After reset the block clears its slot occupancy memory
// with busy high. An insert scans every slot of the value memory, one read
// per cycle, then writes the entry and links its neighbours to it, the
// latter not in an empty ring; a duplicate or a full ring ends it unlinked.
// A remove reads the cursor's links and unlinks its entry; a query, or a
// remove or move on an empty ring, only reads out the result. A move walks
// the link memory by the step count's magnitude modulo the entry count, so
// fewer steps than entries, each with a read state and an advance state.
// ----------------------------------------------------------------------------
module unique_value_ring_with_cursor_top
  import uvr_pkg::*;
#(
  parameter int RING_CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int SW = $clog2(RING_CAPACITY);
  localparam int CW = $clog2(RING_CAPACITY + 1);

  state_t state, state_next;

  logic [31:0] val_mem [RING_CAPACITY];
  logic [SW-1:0] nxt_mem [RING_CAPACITY];
  logic [SW-1:0] prv_mem [RING_CAPACITY];
  logic use_mem [RING_CAPACITY];

  logic [31:0]   val_rd;
  logic [SW-1:0] nxt_rd, prv_rd;
  logic          use_rd;

  logic          val_we;
  logic [SW-1:0] val_waddr, val_raddr;
  logic          nxt_we, prv_we, use_we;
  logic [SW-1:0] nxt_waddr, nxt_wdata, nxt_raddr;
  logic [SW-1:0] prv_waddr, prv_wdata, prv_raddr;
  logic [SW-1:0] use_addr;
  logic          use_wdata;

  req_t          req_q, req_q_next;
  logic [SW-1:0] cursor, cursor_next;
  logic [CW-1:0] ring_size, ring_size_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic          scan_pend, scan_pend_next;
  logic [SW-1:0] pend_idx, pend_idx_next;
  logic          dup_hit, dup_hit_next;
  logic          free_hit, free_hit_next;
  logic [SW-1:0] free_slot, free_slot_next;
  logic [SW-1:0] nbr_slot, nbr_slot_next;
  logic [CW-1:0] steps, steps_next;
  status_e       status_q, status_q_next;
  logic          done_next;
  rsp_t          result_next;
  logic [CW-1:0] clr_idx, clr_idx_next;

  logic              accept;
  logic              rem_start, rem_done;
  logic [CW-1:0]     rem_val;
  logic [STEP_W-1:0] step_raw, step_abs;
  logic              ring_full;
  logic [CW+4:0]     count_ext;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign ring_full = (ring_size == CW'(RING_CAPACITY));
  assign step_raw  = request.step_count;
  assign step_abs  = step_raw[STEP_W-1] ? (STEP_W'(0) - step_raw) : step_raw;
  assign rem_start = accept && (request.req_type == REQ_MOVE) && (ring_size != '0);
  assign count_ext = (CW+5)'(ring_size);

  uvr_rem #(
    .DW(STEP_W),
    .VW(CW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (step_abs),
    .divisor  (ring_size),
    .done     (rem_done),
    .remainder(rem_val)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == CW'(RING_CAPACITY - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (request.req_type)
            REQ_INSERT: state_next = S_INS_SCAN;
            REQ_REMOVE: state_next = (ring_size == '0) ? S_FIN_RD : S_REM_RD;
            REQ_MOVE:   state_next = (ring_size == '0) ? S_FIN_RD : S_MV_DIV;
            default:    state_next = S_FIN_RD;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (scan_idx == CW'(RING_CAPACITY) && !scan_pend) state_next = S_INS_DECIDE;
      end
      S_INS_DECIDE: state_next = (dup_hit || ring_full) ? S_FIN_RD : S_INS_LINK1;
      S_INS_LINK1:  state_next = (ring_size == '0) ? S_FIN_RD : S_INS_LINK2;
      S_INS_LINK2:  state_next = S_FIN_RD;
      S_REM_RD:     state_next = S_REM_LINK;
      S_REM_LINK:   state_next = S_FIN_RD;
      S_MV_DIV: begin
        if (rem_done) state_next = (rem_val == '0) ? S_FIN_RD : S_MV_RD;
      end
      S_MV_RD:  state_next = S_MV_ADV;
      S_MV_ADV: state_next = (steps == CW'(1)) ? S_FIN_RD : S_MV_RD;
      S_FIN_RD: state_next = S_FIN_OUT;
      S_FIN_OUT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_q_next     = req_q;
    cursor_next    = cursor;
    ring_size_next = ring_size;
    scan_idx_next  = scan_idx;
    scan_pend_next = scan_pend;
    pend_idx_next  = pend_idx;
    dup_hit_next   = dup_hit;
    free_hit_next  = free_hit;
    free_slot_next = free_slot;
    nbr_slot_next  = nbr_slot;
    steps_next     = steps;
    status_q_next  = status_q;
    done_next      = 1'b0;
    result_next    = result;
    clr_idx_next   = clr_idx;

    val_we    = 1'b0;
    val_waddr = free_slot;
    val_raddr = cursor;
    nxt_we    = 1'b0;
    nxt_waddr = cursor;
    nxt_wdata = free_slot;
    nxt_raddr = cursor;
    prv_we    = 1'b0;
    prv_waddr = cursor;
    prv_wdata = free_slot;
    prv_raddr = cursor;
    use_we    = 1'b0;
    use_addr  = cursor;
    use_wdata = 1'b0;

    case (state)
      S_CLEAR: begin
        use_we       = 1'b1;
        use_addr     = clr_idx[SW-1:0];
        use_wdata    = 1'b0;
        clr_idx_next = clr_idx + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          req_q_next     = request;
          scan_idx_next  = '0;
          scan_pend_next = 1'b0;
          dup_hit_next   = 1'b0;
          free_hit_next  = 1'b0;
          free_slot_next = '0;
          status_q_next  = STAT_DONE;
          if ((request.req_type == REQ_REMOVE || request.req_type == REQ_MOVE)
              && ring_size == '0) begin
            status_q_next = STAT_EMPTY;
          end
        end
      end
      S_INS_SCAN: begin
        val_raddr     = scan_idx[SW-1:0];
        use_addr      = scan_idx[SW-1:0];
        nbr_slot_next = nxt_rd;
        if (scan_idx != CW'(RING_CAPACITY)) begin
          scan_idx_next  = scan_idx + 1'b1;
          scan_pend_next = 1'b1;
          pend_idx_next  = scan_idx[SW-1:0];
        end else begin
          scan_pend_next = 1'b0;
        end
        if (scan_pend) begin
          if (use_rd && (val_rd == req_q.item_value)) dup_hit_next = 1'b1;
          if (!use_rd && !free_hit) begin
            free_hit_next  = 1'b1;
            free_slot_next = pend_idx;
          end
        end
      end
      S_INS_DECIDE: begin
        if (dup_hit) status_q_next = STAT_DUP;
        else if (ring_full) status_q_next = STAT_FULL;
      end
      S_INS_LINK1: begin
        val_we         = 1'b1;
        val_waddr      = free_slot;
        nxt_we         = 1'b1;
        nxt_waddr      = free_slot;
        nxt_wdata      = (ring_size == '0) ? free_slot : nbr_slot;
        prv_we         = 1'b1;
        prv_waddr      = free_slot;
        prv_wdata      = (ring_size == '0) ? free_slot : cursor;
        use_we         = 1'b1;
        use_addr       = free_slot;
        use_wdata      = 1'b1;
        ring_size_next = ring_size + 1'b1;
        if (ring_size == '0) cursor_next = free_slot;
      end
      S_INS_LINK2: begin
        nxt_we      = 1'b1;
        nxt_waddr   = cursor;
        nxt_wdata   = free_slot;
        prv_we      = 1'b1;
        prv_waddr   = nbr_slot;
        prv_wdata   = free_slot;
        cursor_next = free_slot;
      end
      S_REM_LINK: begin
        use_we         = 1'b1;
        use_addr       = cursor;
        use_wdata      = 1'b0;
        ring_size_next = ring_size - 1'b1;
        if (ring_size != CW'(1)) begin
          nxt_we      = 1'b1;
          nxt_waddr   = prv_rd;
          nxt_wdata   = nxt_rd;
          prv_we      = 1'b1;
          prv_waddr   = nxt_rd;
          prv_wdata   = prv_rd;
          cursor_next = prv_rd;
        end
      end
      S_MV_DIV: begin
        if (rem_done) steps_next = rem_val;
      end
      S_MV_ADV: begin
        cursor_next = req_q.step_count[STEP_W-1] ? prv_rd : nxt_rd;
        steps_next  = steps - 1'b1;
      end
      S_FIN_OUT: begin
        done_next                 = 1'b1;
        result_next.status        = status_q;
        result_next.current_value = (ring_size != '0) ? val_rd : '0;
        result_next.ring_empty    = (ring_size == '0);
        result_next.entry_count   = count_ext[4:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= req_q.item_value;
    val_rd <= val_mem[val_raddr];
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_rd <= nxt_mem[nxt_raddr];
    if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
    prv_rd <= prv_mem[prv_raddr];
    if (use_we) use_mem[use_addr] <= use_wdata;
    use_rd <= use_mem[use_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      cursor    <= '0;
      ring_size <= '0;
      scan_pend <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      cursor    <= cursor_next;
      ring_size <= ring_size_next;
      scan_pend <= scan_pend_next;
      done      <= done_next;
    end
    req_q     <= req_q_next;
    scan_idx  <= scan_idx_next;
    pend_idx  <= pend_idx_next;
    dup_hit   <= dup_hit_next;
    free_hit  <= free_hit_next;
    free_slot <= free_slot_next;
    nbr_slot  <= nbr_slot_next;
    steps     <= steps_next;
    status_q  <= status_q_next;
    result    <= result_next;
  end

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    ring_size <= CW'(RING_CAPACITY))
    else $error("Entry count exceeds the ring capacity.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.ring_empty == (ring_size == '0)))
    else $error("Empty flag disagrees with the entry count.");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.ring_empty) |-> (result.current_value == '0))
    else $error("Empty ring reports a nonzero current value.");

  a_walk_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_MV_DIV && rem_done) |-> (rem_val < ring_size))
    else $error("Cursor walk length is not below the entry count.");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_LINK1) |-> (free_hit && !dup_hit && !ring_full))
    else $error("Insert links an entry without a free slot.");

endmodule
